[rtl/core/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication from an antecedent to a consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication from an antecedent to a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spa_pkg.sv]
// shared constants and types for the sparse polynomial adder
`default_nettype none

package spa_pkg;

    localparam int MAX_TERMS_DEF = 32;

    localparam int FUNC_W = 2;
    localparam int COEF_W = 32;
    localparam int EXPN_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN         = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [EXPN_W-1:0]        expn;
    } term_t;

endpackage

`default_nettype wire

[rtl/core/sparse_polynomial_add.sv]
// Sparse polynomial adder. Load transactions (func 0 for the first polynomial, func 1 for the
// second) take one cycle each and write one (coef, expn) term into that polynomial's term
// memory; a load into a full memory is dropped and sets the overflow flag. A run transaction
// (func 2) merges both memories by ascending exponent: the sequencer reads one term from each
// memory per cycle and uses a single saturating adder and exponent comparator, so a run takes
// one cycle per merge step (first count + second count - equal-exponent pairs) plus one cycle
// to close, plus any cycles the result port is held off. One result is kept pending so that
// the final term can carry last; an all-zero sum gives one result with empty_res set. The
// block takes no transaction while a run is in progress. Counts and overflow clear at run end.
`default_nettype none

module sparse_polynomial_add
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [COEF_W-1:0] coef,
    input  logic [EXPN_W-1:0]        expn,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic signed [COEF_W-1:0] sum_coef,
    output logic [EXPN_W-1:0]        sum_expn,
    output logic                     last,
    output logic                     empty_res,
    output logic                     overflow
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    term_t first_mem  [MAX_TERMS];
    term_t second_mem [MAX_TERMS];

    logic             state_reg;
    logic [CNT_W-1:0] first_cnt_reg;
    logic [CNT_W-1:0] second_cnt_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] i_next;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] j_next;
    term_t            a_rd_reg;
    term_t            b_rd_reg;
    term_t            pend_reg;
    logic             pend_vld_reg;
    logic             res_valid_reg;
    logic signed [COEF_W-1:0] sum_coef_reg;
    logic [EXPN_W-1:0]        sum_expn_reg;
    logic                     last_reg;
    logic                     empty_reg;
    logic                     ovf_out_reg;

    logic                   accept;
    logic                   can_move;
    logic                   step;
    logic                   a_ok;
    logic                   b_ok;
    logic                   take_a;
    logic                   take_b;
    logic                   finish;
    logic                   cand_vld;
    term_t                  cand;
    logic signed [COEF_W:0] sum_wide;
    logic signed [COEF_W-1:0] sum_sat;
    logic                   out_load;

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign can_move   = !res_valid_reg || res_ready;
    assign step       = (state_reg == S_RUN) && can_move;

    assign sum_wide = {a_rd_reg.coef[COEF_W-1], a_rd_reg.coef}
                    + {b_rd_reg.coef[COEF_W-1], b_rd_reg.coef};

    always_comb
    begin
        if (sum_wide[COEF_W] != sum_wide[COEF_W-1])
        begin
            sum_sat = sum_wide[COEF_W] ? COEF_MIN : COEF_MAX;
        end
        else
        begin
            sum_sat = sum_wide[COEF_W-1:0];
        end
    end

    // merge decision on the two head terms
    always_comb
    begin
        a_ok     = (i_reg < first_cnt_reg);
        b_ok     = (j_reg < second_cnt_reg);
        take_a   = 1'b0;
        take_b   = 1'b0;
        finish   = 1'b0;
        cand_vld = 1'b0;
        cand     = a_rd_reg;
        if (a_ok && b_ok)
        begin
            if (a_rd_reg.expn < b_rd_reg.expn)
            begin
                take_a   = 1'b1;
                cand_vld = 1'b1;
            end
            else if (a_rd_reg.expn > b_rd_reg.expn)
            begin
                take_b   = 1'b1;
                cand_vld = 1'b1;
                cand     = b_rd_reg;
            end
            else
            begin
                take_a    = 1'b1;
                take_b    = 1'b1;
                cand.coef = sum_sat;
                cand_vld  = (sum_sat != '0);
            end
        end
        else if (a_ok)
        begin
            take_a   = 1'b1;
            cand_vld = 1'b1;
        end
        else if (b_ok)
        begin
            take_b   = 1'b1;
            cand_vld = 1'b1;
            cand     = b_rd_reg;
        end
        else
        begin
            finish = 1'b1;
        end
    end

    always_comb
    begin
        if (step && take_a)
        begin
            i_next = i_reg + 1'b1;
        end
        else if (state_reg == S_IDLE)
        begin
            i_next = '0;
        end
        else
        begin
            i_next = i_reg;
        end
        if (step && take_b)
        begin
            j_next = j_reg + 1'b1;
        end
        else if (state_reg == S_IDLE)
        begin
            j_next = '0;
        end
        else
        begin
            j_next = j_reg;
        end
    end

    assign out_load = step && ((cand_vld && pend_vld_reg) || finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_vld_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (func)
                            FUNC_LOAD_FIRST:
                            begin
                                if (first_cnt_reg < CNT_W'(MAX_TERMS))
                                begin
                                    first_cnt_reg <= first_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            FUNC_LOAD_SECOND:
                            begin
                                if (second_cnt_reg < CNT_W'(MAX_TERMS))
                                begin
                                    second_cnt_reg <= second_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            FUNC_RUN:
                            begin
                                state_reg <= S_RUN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (step)
                    begin
                        if (finish)
                        begin
                            state_reg      <= S_IDLE;
                            first_cnt_reg  <= '0;
                            second_cnt_reg <= '0;
                            ovf_reg        <= 1'b0;
                            pend_vld_reg   <= 1'b0;
                        end
                        else if (cand_vld)
                        begin
                            pend_vld_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // term memories, one write and one registered read port each
    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_LOAD_FIRST && first_cnt_reg < CNT_W'(MAX_TERMS))
        begin
            first_mem[first_cnt_reg[IDX_W-1:0]] <= '{coef: coef, expn: expn};
        end
        a_rd_reg <= first_mem[i_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_LOAD_SECOND && second_cnt_reg < CNT_W'(MAX_TERMS))
        begin
            second_mem[second_cnt_reg[IDX_W-1:0]] <= '{coef: coef, expn: expn};
        end
        b_rd_reg <= second_mem[j_next[IDX_W-1:0]];
    end

    // pending term and result register
    always_ff @(posedge clk)
    begin
        if (step && cand_vld)
        begin
            pend_reg <= cand;
        end
        if (out_load)
        begin
            last_reg    <= finish;
            ovf_out_reg <= ovf_reg;
            if (finish && !pend_vld_reg)
            begin
                sum_coef_reg <= '0;
                sum_expn_reg <= '0;
                empty_reg    <= 1'b1;
            end
            else
            begin
                sum_coef_reg <= pend_reg.coef;
                sum_expn_reg <= pend_reg.expn;
                empty_reg    <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign sum_coef  = sum_coef_reg;
    assign sum_expn  = sum_expn_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;
    assign overflow  = ovf_out_reg;

endmodule

`default_nettype wire

[rtl/core/spa_checker.sv]
// port-level checker for the sparse polynomial adder, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module spa_checker
    import spa_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_ready,
    input logic [FUNC_W-1:0]        func,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic signed [COEF_W-1:0] sum_coef,
    input logic [EXPN_W-1:0]        sum_expn,
    input logic                     last,
    input logic                     empty_res
);

    // held result stays put
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(sum_coef) && $stable(sum_expn) && $stable(last) && $stable(empty_res), "result changed while held")

    // an empty sum is a single zero term that closes the run
    `ASSERT_IMPL(a_empty_form, clk, rst_n, res_valid && empty_res, last && (sum_coef == '0) && (sum_expn == '0), "malformed empty result")

    // a run transaction blocks further transactions
    `ASSERT_NEXT(a_run_busy, clk, rst_n, item_valid && item_ready && (func == FUNC_RUN), !item_ready, "ready after run transaction")

    // the block becomes ready again only together with the closing result
    `ASSERT_IMPL(a_ready_last, clk, rst_n, $rose(item_ready), res_valid && last, "ready without closing result")

endmodule

bind sparse_polynomial_add spa_checker u_spa_checker (.*);

`default_nettype wire
